// ----- hw/rtl/psta_pkg.sv -----
package psta_pkg;

  // Field widths of the point and result beats.
  localparam int COORD_W = 24;
  localparam int SPEED_W = 18;
  localparam int TIME_W  = 48;

  // Internal datapath widths.
  localparam int SSUM_W  = SPEED_W + 1;        // sum of two speeds
  localparam int SQ_W    = 2 * COORD_W;        // one squared difference
  localparam int RAD_W   = 64;                 // radicand, length squared times 2^14
  localparam int RAD_SH  = 14;
  localparam int ROOT_W  = 32;                 // floor of the square root
  localparam int QUO_SH  = 10;
  localparam int QUO_W   = ROOT_W + QUO_SH;    // numerator and quotient of the divide
  localparam int ROOT_STEPS = 32;
  localparam int DIV_STEPS  = QUO_W;
  localparam int ITER_W  = 6;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_LOOP_CLOSED = 1'b0;

  // Request to the segment time unit.
  typedef struct packed {
    logic                      start;
    logic signed [COORD_W-1:0] x_a;
    logic signed [COORD_W-1:0] y_a;
    logic        [SPEED_W-1:0] v_a;
    logic signed [COORD_W-1:0] x_b;
    logic signed [COORD_W-1:0] y_b;
    logic        [SPEED_W-1:0] v_b;
  } seg_req_t;

  // Answer of the segment time unit, valid while done is high.
  typedef struct packed {
    logic              done;
    logic              zero_speed;
    logic [QUO_W-1:0]  seg_time;
  } seg_rsp_t;

endpackage

// ----- hw/rtl/psta_point_if.sv -----
interface psta_point_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [psta_pkg::COORD_W-1:0]        x_pos;
  logic signed [psta_pkg::COORD_W-1:0]        y_pos;
  logic        [psta_pkg::SPEED_W-1:0]        speed;
  logic                                       last_point;

  modport source (output valid, x_pos, y_pos, speed, last_point, input ready);
  modport sink   (input valid, x_pos, y_pos, speed, last_point, output ready);
endinterface

// ----- hw/rtl/psta_time_if.sv -----
interface psta_time_if;
  logic                            valid;
  logic                            ready;
  logic [psta_pkg::TIME_W-1:0]     elapsed_time;
  logic                            time_infinite;
  logic                            is_loop_total;
  logic                            last_result;

  modport source (output valid, elapsed_time, time_infinite, is_loop_total, last_result,
                  input ready);
  modport sink   (input valid, elapsed_time, time_infinite, is_loop_total, last_result,
                  output ready);
endinterface

// ----- hw/rtl/psta_apb.sv -----
module psta_apb (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psta_pkg::PADDR_W-1:0]  paddr,
  input  logic [psta_pkg::PDATA_W-1:0]  pwdata,
  output logic [psta_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output logic                          loop_closed
);

  logic reg_hit;

  // Register select by word index.
  assign reg_hit = (paddr[psta_pkg::PADDR_W-1:2] == psta_pkg::REG_LOOP_CLOSED);
  assign pready  = 1'b1;

  // Write in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      loop_closed <= 1'b0;
    end else if (psel && penable && pwrite && reg_hit) begin
      loop_closed <= pwdata[0];
    end
  end

  // Read back.
  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata[0] = loop_closed;
    end
  end

endmodule

// ----- hw/rtl/psta_sub.sv -----
module psta_sub (
  input  logic [psta_pkg::RAD_W-1:0] a,
  input  logic [psta_pkg::RAD_W-1:0] b,
  output logic [psta_pkg::RAD_W-1:0] diff,
  output logic                       ge
);

  logic [psta_pkg::RAD_W:0] full;

  // One wide subtract; the borrow out doubles as the compare.
  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[psta_pkg::RAD_W-1:0];
  assign ge   = ~full[psta_pkg::RAD_W];

endmodule

// ----- hw/rtl/psta_seg.sv -----
module psta_seg (
  input  logic                clk,
  input  logic                rst,
  input  psta_pkg::seg_req_t  req,
  output psta_pkg::seg_rsp_t  rsp
);

  typedef enum logic [6:0] {
    SG_IDLE = 7'b0000001,
    SG_DIFF = 7'b0000010,
    SG_SQX  = 7'b0000100,
    SG_SQY  = 7'b0001000,
    SG_SUM  = 7'b0010000,
    SG_ROOT = 7'b0100000,
    SG_DIV  = 7'b1000000
  } seg_state_t;

  seg_state_t state;
  seg_state_t state_next;

  // Operands latched at start.
  logic signed [psta_pkg::COORD_W-1:0] x_a, y_a, x_b, y_b;
  logic        [psta_pkg::SPEED_W-1:0] v_a, v_b;

  logic [psta_pkg::COORD_W-1:0] dx, dy;
  logic [psta_pkg::SSUM_W-1:0]  ssum;
  logic [psta_pkg::SQ_W-1:0]    prod;
  logic [psta_pkg::SQ_W-1:0]    sq_x;
  logic [psta_pkg::RAD_W-1:0]   rad;
  logic [psta_pkg::RAD_W-1:0]   root;
  logic [psta_pkg::RAD_W-1:0]   bitm;
  logic [psta_pkg::SSUM_W-1:0]  rem;
  logic [psta_pkg::QUO_W-1:0]   quo;
  logic [psta_pkg::ITER_W-1:0]  iter;
  logic                         done;

  logic signed [psta_pkg::COORD_W:0] diff_x, diff_y;
  logic [psta_pkg::COORD_W:0]        mag_x, mag_y;
  logic [psta_pkg::COORD_W-1:0]      mul_in;
  logic [psta_pkg::SQ_W:0]           sq_sum;
  logic [psta_pkg::SSUM_W:0]         rem_sh;
  logic [psta_pkg::RAD_W-1:0]        sub_a, sub_b, sub_diff;
  logic                              sub_ge;
  logic [psta_pkg::RAD_W-1:0]        root_step;

  // Signed differences and their magnitudes.
  assign diff_x = {x_a[psta_pkg::COORD_W-1], x_a} - {x_b[psta_pkg::COORD_W-1], x_b};
  assign diff_y = {y_a[psta_pkg::COORD_W-1], y_a} - {y_b[psta_pkg::COORD_W-1], y_b};
  assign mag_x  = diff_x[psta_pkg::COORD_W] ? -diff_x : diff_x;
  assign mag_y  = diff_y[psta_pkg::COORD_W] ? -diff_y : diff_y;

  // The one multiplier squares dx, then dy.
  assign mul_in = (state == SG_SQX) ? dx : dy;
  assign sq_sum = {1'b0, sq_x} + {1'b0, prod};

  // Shared subtractor: square root trial in one phase, divide trial in the other.
  assign rem_sh = {rem, quo[psta_pkg::QUO_W-1]};
  always_comb begin
    if (state == SG_ROOT) begin
      sub_a = rad;
      sub_b = root | bitm;
    end else begin
      sub_a = {{(psta_pkg::RAD_W-psta_pkg::SSUM_W-1){1'b0}}, rem_sh};
      sub_b = {{(psta_pkg::RAD_W-psta_pkg::SSUM_W){1'b0}}, ssum};
    end
  end

  psta_sub u_sub (
    .a    (sub_a),
    .b    (sub_b),
    .diff (sub_diff),
    .ge   (sub_ge)
  );

  // Next partial root of one square root step.
  assign root_step = sub_ge ? ((root >> 1) | bitm) : (root >> 1);

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      SG_IDLE: if (req.start) state_next = SG_DIFF;
      SG_DIFF: state_next = SG_SQX;
      SG_SQX:  state_next = SG_SQY;
      SG_SQY:  state_next = SG_SUM;
      SG_SUM:  state_next = SG_ROOT;
      SG_ROOT: if (iter == psta_pkg::ITER_W'(psta_pkg::ROOT_STEPS - 1)) state_next = SG_DIV;
      SG_DIV:  if (iter == psta_pkg::ITER_W'(psta_pkg::DIV_STEPS - 1)) state_next = SG_IDLE;
      default: state_next = SG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SG_IDLE;
      done  <= 1'b0;
      iter  <= '0;
    end else begin
      state <= state_next;
      done  <= (state == SG_DIV) && (state_next == SG_IDLE);
      if ((state == SG_ROOT || state == SG_DIV) && state_next == state) begin
        iter <= iter + 1'b1;
      end else begin
        iter <= '0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      SG_IDLE: begin
        if (req.start) begin
          x_a <= req.x_a;
          y_a <= req.y_a;
          v_a <= req.v_a;
          x_b <= req.x_b;
          y_b <= req.y_b;
          v_b <= req.v_b;
        end
      end
      SG_DIFF: begin
        dx   <= mag_x[psta_pkg::COORD_W-1:0];
        dy   <= mag_y[psta_pkg::COORD_W-1:0];
        ssum <= {1'b0, v_a} + {1'b0, v_b};
      end
      SG_SQX: begin
        prod <= mul_in * mul_in;
      end
      SG_SQY: begin
        sq_x <= prod;
        prod <= mul_in * mul_in;
      end
      SG_SUM: begin
        rad  <= {{(psta_pkg::RAD_W-psta_pkg::SQ_W-1-psta_pkg::RAD_SH){1'b0}}, sq_sum,
                 {psta_pkg::RAD_SH{1'b0}}};
        root <= '0;
        bitm <= {2'b01, {(psta_pkg::RAD_W-2){1'b0}}};
      end
      SG_ROOT: begin
        // One result bit per step, restoring form.
        if (sub_ge) begin
          rad <= sub_diff;
        end
        root <= root_step;
        bitm <= bitm >> 2;
        if (state_next == SG_DIV) begin
          rem <= '0;
          quo <= {root_step[psta_pkg::ROOT_W-1:0], {psta_pkg::QUO_SH{1'b0}}};
        end
      end
      SG_DIV: begin
        // Restoring divide, one quotient bit per step.
        if (sub_ge) begin
          rem <= sub_diff[psta_pkg::SSUM_W-1:0];
        end else begin
          rem <= rem_sh[psta_pkg::SSUM_W-1:0];
        end
        quo <= {quo[psta_pkg::QUO_W-2:0], sub_ge};
      end
      default: ;
    endcase
  end

  assign rsp.done       = done;
  assign rsp.zero_speed = (ssum == '0);
  assign rsp.seg_time   = quo;

endmodule

// ----- hw/rtl/path_segment_time_accumulator_core.sv -----
// Path segment time accumulator.
// Point beats enter on the points channel (x_pos, y_pos, speed, last_point);
// time beats leave on the times channel (elapsed_time in 1/65536 s,
// time_infinite, is_loop_total, last_result). Both use valid/ready.
// The APB register loop_closed adds a loop total beat after the last point.
// The first point of a path answers without a segment, through the emit state
// and the output register. Every later point runs one segment through the shared
// unit: difference, two squarings on a single multiplier, a 32-step square root
// and a 42-step divide on one shared 64-bit subtractor; its beat becomes valid
// as the next point can be taken. A last point with loop_closed set runs a
// second, closing segment; its loop total beat follows the beat of that point.
// Points are taken only while the sequencer is idle; one finished beat may
// wait in the output register while the next point is already accepted.
// When the receiver stalls, the block finishes its work and then holds until
// the output register frees. Reset clears the path, the time, the infinite
// flag and loop_closed; the block is ready once reset is released.
module path_segment_time_accumulator_core (
  input  logic                          clk,
  input  logic                          rst,
  psta_point_if.sink                    points,
  psta_time_if.source                   times,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psta_pkg::PADDR_W-1:0]  paddr,
  input  logic [psta_pkg::PDATA_W-1:0]  pwdata,
  output logic [psta_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SEG   = 5'b00010,
    ST_EMIT  = 5'b00100,
    ST_CLOSE = 5'b01000,
    ST_TOTAL = 5'b10000
  } ctl_state_t;

  ctl_state_t state;
  ctl_state_t state_next;

  logic loop_closed;

  logic signed [psta_pkg::COORD_W-1:0] prev_x, prev_y, first_x, first_y;
  logic        [psta_pkg::SPEED_W-1:0] prev_speed, first_speed;
  logic        [psta_pkg::TIME_W-1:0]  run_time;
  logic                                inf_flag;
  logic                                path_started;
  logic                                cur_last;

  logic                                out_valid;
  logic        [psta_pkg::TIME_W-1:0]  out_time;
  logic                                out_inf;
  logic                                out_loop;
  logic                                out_last;

  psta_pkg::seg_req_t seg_req;
  psta_pkg::seg_rsp_t seg_rsp;

  logic                                accept;
  logic                                out_free;
  logic                                out_load;
  logic [psta_pkg::TIME_W:0]           time_sum;
  logic [psta_pkg::TIME_W-1:0]         time_sat;

  psta_apb u_apb (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .loop_closed (loop_closed)
  );

  psta_seg u_seg (
    .clk (clk),
    .rst (rst),
    .req (seg_req),
    .rsp (seg_rsp)
  );

  assign points.ready = (state == ST_IDLE);
  assign accept       = points.valid && points.ready;
  assign out_free     = !out_valid || times.ready;
  assign out_load     = out_free && (state == ST_EMIT || state == ST_TOTAL);

  // Saturating accumulate of one segment time.
  assign time_sum = {1'b0, run_time}
                  + {{(psta_pkg::TIME_W + 1 - psta_pkg::QUO_W){1'b0}}, seg_rsp.seg_time};
  assign time_sat = time_sum[psta_pkg::TIME_W] ? {psta_pkg::TIME_W{1'b1}}
                                               : time_sum[psta_pkg::TIME_W-1:0];

  // Segment requests: previous to new point, or last point back to the first.
  always_comb begin
    seg_req.start = 1'b0;
    seg_req.x_a   = prev_x;
    seg_req.y_a   = prev_y;
    seg_req.v_a   = prev_speed;
    seg_req.x_b   = first_x;
    seg_req.y_b   = first_y;
    seg_req.v_b   = first_speed;
    if (state == ST_IDLE) begin
      seg_req.start = accept && path_started;
      seg_req.x_b   = points.x_pos;
      seg_req.y_b   = points.y_pos;
      seg_req.v_b   = points.speed;
    end else if (state == ST_EMIT) begin
      seg_req.start = out_load && cur_last && loop_closed;
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = path_started ? ST_SEG : ST_EMIT;
      ST_SEG:   if (seg_rsp.done) state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = (cur_last && loop_closed) ? ST_CLOSE : ST_IDLE;
        end
      end
      ST_CLOSE: if (seg_rsp.done) state_next = ST_TOTAL;
      ST_TOTAL: if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control state and path bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      path_started <= 1'b0;
      run_time     <= '0;
      inf_flag     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && !path_started) begin
        path_started <= 1'b1;
        run_time     <= '0;
        inf_flag     <= 1'b0;
      end
      if ((state == ST_SEG || state == ST_CLOSE) && seg_rsp.done) begin
        if (seg_rsp.zero_speed) begin
          inf_flag <= 1'b1;
        end else begin
          run_time <= time_sat;
        end
      end
      if (out_load && cur_last && (state == ST_TOTAL || !loop_closed)) begin
        path_started <= 1'b0;
        run_time     <= '0;
        inf_flag     <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (times.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Point registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      prev_x     <= points.x_pos;
      prev_y     <= points.y_pos;
      prev_speed <= points.speed;
      cur_last   <= points.last_point;
      if (!path_started) begin
        first_x     <= points.x_pos;
        first_y     <= points.y_pos;
        first_speed <= points.speed;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_time <= inf_flag ? {psta_pkg::TIME_W{1'b1}} : run_time;
      out_inf  <= inf_flag;
      out_loop <= (state == ST_TOTAL);
      out_last <= cur_last && ((state == ST_TOTAL) || !loop_closed);
    end
  end

  assign times.valid         = out_valid;
  assign times.elapsed_time  = out_time;
  assign times.time_infinite = out_inf;
  assign times.is_loop_total = out_loop;
  assign times.last_result   = out_last;

  // The segment unit answers only while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    seg_rsp.done |-> (state == ST_SEG || state == ST_CLOSE))
    else $error("segment answer outside a wait state");

  // A loop total is always the final beat of its path.
  a_loop_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_loop |-> out_last)
    else $error("loop total beat without last_result");

  // An infinite time reads as the saturated maximum.
  a_inf_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_inf |-> (out_time == {psta_pkg::TIME_W{1'b1}}))
    else $error("infinite time not at maximum");

  // One point at a time: no second point in the cycle after an accept.
  a_one_point: assert property (@(posedge clk) disable iff (rst)
    accept |=> !points.ready)
    else $error("point accepted while busy");

endmodule
